FILE: src/tdq_pkg.sv
`timescale 1ns / 1ps

package tdq_pkg;

    // Ring store geometry
    localparam int DEPTH = 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;

    // Token layout: code in the upper byte, value in the lower word
    localparam int CODE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int TOK_W   = CODE_W + VALUE_W;
    localparam int OFS_W   = 8;
    localparam int CNT_W   = 9;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4,
        OP_SEARCH     = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN
    } t_state;

    // Advance ring index a by b entries, b at most DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = {{(SW-AW){1'b0}}, a} + {1'b0, b};
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Step ring index back by one entry
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
        return r;
    endfunction

endpackage

FILE: src/tdq_ram.sv
`timescale 1ns / 1ps

module tdq_ram #(
    parameter int P_DW    = 40,
    parameter int P_AW    = 8,
    parameter int P_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [P_AW-1:0] i_waddr,
    input  logic [P_DW-1:0] i_wdata,
    input  logic [P_AW-1:0] i_raddr_a,
    input  logic [P_AW-1:0] i_raddr_b,
    output logic [P_DW-1:0] o_rdata_a,
    output logic [P_DW-1:0] o_rdata_b
);

    logic [P_DW-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/token_deque_peek_search_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Fields
// command   in         start && !busy       i_op, i_token_code, i_token_value, i_offset
// result    out        o_done (one cycle)   o_status, o_out_code, o_out_value, o_found,
//                                           o_count
//
// Push, clear, unused codes, pops and searches of an empty deque, out-of-range peeks:
// the result strobe is registered from the execute state. Pop and peek: the result
// follows the registered read of the token store. Search: the dual-port store feeds
// one front and one back entry per cycle to the key compare until a hit or the walks meet.
// Synchronous active-low reset empties the deque; no clearing pass over the store.
// busy stays high from the accepting edge through the cycle before the strobe; the
// result is never stalled, and a new command may be taken in the strobe cycle.

module token_deque_peek_search_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_token_code,
    input  logic signed [31:0] i_token_value,
    input  logic [7:0]         i_offset,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [7:0]         o_out_code,
    output logic signed [31:0] o_out_value,
    output logic               o_found,
    output logic [8:0]         o_count
);

    import tdq_pkg::*;

    // Sequencer and deque pointers
    t_state              r_state,  n_state;
    logic [AW-1:0]       r_front,  n_front;
    logic [CW-1:0]       r_count,  n_count;
    logic                r_done,   n_done;

    // Latched transaction
    t_op                 r_op,     n_op;
    logic [CODE_W-1:0]   r_code,   n_code;
    logic [VALUE_W-1:0]  r_value,  n_value;
    logic [OFS_W-1:0]    r_offset, n_offset;

    // Search walk: front-side pointer, back-side pointer, distance between them
    logic [AW-1:0]       r_pa,     n_pa;
    logic [AW-1:0]       r_pb,     n_pb;
    logic [CW-1:0]       r_gap,    n_gap;

    // Result payload
    t_status             r_status, n_status;
    logic [CODE_W-1:0]   r_ocode,  n_ocode;
    logic [VALUE_W-1:0]  r_ovalue, n_ovalue;
    logic                r_found,  n_found;

    // Store access
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr_a;
    logic [AW-1:0]       w_raddr_b;
    logic [TOK_W-1:0]    w_rdata_a;
    logic [TOK_W-1:0]    w_rdata_b;
    logic [TOK_W-1:0]    w_key;

    logic                w_full;
    logic                w_empty;
    logic                w_hit;
    logic [CW+OFS_W-1:0] w_ofs_ext;
    logic [CW+OFS_W-1:0] w_cnt_ext;
    logic [CW+CNT_W-1:0] w_cnt_out;

    assign w_key     = {r_code, r_value};
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_ofs_ext = {{CW{1'b0}}, r_offset};
    assign w_cnt_ext = {{OFS_W{1'b0}}, r_count};
    assign w_hit     = (w_rdata_a == w_key) || (w_rdata_b == w_key);

    tdq_ram #(
        .P_DW    (TOK_W),
        .P_AW    (AW),
        .P_DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_key),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_code   <= n_code;
        r_value  <= n_value;
        r_offset <= n_offset;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_gap    <= n_gap;
        r_status <= n_status;
        r_ocode  <= n_ocode;
        r_ovalue <= n_ovalue;
        r_found  <= n_found;
    end

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_done    = 1'b0;
        n_op      = r_op;
        n_code    = r_code;
        n_value   = r_value;
        n_offset  = r_offset;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_gap     = r_gap;
        n_status  = r_status;
        n_ocode   = r_ocode;
        n_ovalue  = r_ovalue;
        n_found   = r_found;
        w_we      = 1'b0;
        w_waddr   = r_front;
        w_raddr_a = r_pa;
        w_raddr_b = r_pb;

        unique case (r_state)
            ST_IDLE: begin
                // Capture the command transaction
                if (start) begin
                    n_op     = t_op'(i_op);
                    n_code   = i_token_code;
                    n_value  = i_token_value;
                    n_offset = i_offset;
                    n_state  = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state  = ST_IDLE;
                n_status = STS_OK;
                n_ocode  = '0;
                n_ovalue = '0;
                n_found  = 1'b0;
                case (r_op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        n_done = 1'b1;
                        if (w_full) begin
                            n_status = STS_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                            if (r_op == OP_PUSH_FRONT) begin
                                n_front = ring_dec(r_front);
                                w_waddr = ring_dec(r_front);
                            end else begin
                                w_waddr = ring_add(r_front, r_count);
                            end
                        end
                    end

                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (w_empty) begin
                            n_done   = 1'b1;
                            n_status = STS_EMPTY;
                        end else begin
                            // Drop the entry now, deliver its data after the read
                            n_count = r_count - CW'(1);
                            n_state = ST_READ;
                            if (r_op == OP_POP_FRONT) begin
                                w_raddr_a = r_front;
                                n_front   = ring_add(r_front, CW'(1));
                            end else begin
                                w_raddr_a = ring_add(r_front, r_count - CW'(1));
                            end
                        end
                    end

                    OP_PEEK: begin
                        if (w_ofs_ext >= w_cnt_ext) begin
                            n_done   = 1'b1;
                            n_status = STS_RANGE;
                        end else begin
                            w_raddr_a = ring_add(r_front, w_ofs_ext[CW-1:0]);
                            n_state   = ST_READ;
                        end
                    end

                    OP_SEARCH: begin
                        if (w_empty) begin
                            n_done = 1'b1;
                        end else begin
                            // Start both walks at the two ends of the deque
                            w_raddr_a = r_front;
                            w_raddr_b = ring_add(r_front, r_count - CW'(1));
                            n_pa      = r_front;
                            n_pb      = ring_add(r_front, r_count - CW'(1));
                            n_gap     = r_count - CW'(1);
                            n_state   = ST_SCAN;
                        end
                    end

                    OP_CLEAR: begin
                        n_done  = 1'b1;
                        n_front = '0;
                        n_count = '0;
                    end

                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end

            ST_READ: begin
                n_done   = 1'b1;
                n_status = STS_OK;
                n_ocode  = w_rdata_a[TOK_W-1:VALUE_W];
                n_ovalue = w_rdata_a[VALUE_W-1:0];
                n_found  = 1'b0;
                n_state  = ST_IDLE;
            end

            ST_SCAN: begin
                // Compare the pair fetched last cycle; stop on a hit or when the walks meet
                if (w_hit || (r_gap <= CW'(1))) begin
                    n_done   = 1'b1;
                    n_status = STS_OK;
                    n_ocode  = '0;
                    n_ovalue = '0;
                    n_found  = w_hit;
                    n_state  = ST_IDLE;
                end else begin
                    n_pa      = ring_add(r_pa, CW'(1));
                    n_pb      = ring_dec(r_pb);
                    n_gap     = r_gap - CW'(2);
                    w_raddr_a = ring_add(r_pa, CW'(1));
                    w_raddr_b = ring_dec(r_pb);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_code  = r_ocode;
    assign o_out_value = r_ovalue;
    assign o_found     = r_found;
    assign w_cnt_out   = {{CNT_W{1'b0}}, r_count};
    assign o_count     = w_cnt_out[CNT_W-1:0];

endmodule
